// File: hdl/sacl_pkg.sv
// Shared types and constants for the set-associative LRU cache tag-store model.
package sacl_pkg;

	// Command codes of an input beat.
	localparam logic [1:0] CMD_LOAD     = 2'd0;
	localparam logic [1:0] CMD_STORE    = 2'd1;
	localparam logic [1:0] CMD_MODIFY   = 2'd2;
	// Unassigned code; the block treats it as a load.
	localparam logic [1:0] CMD_RESERVED = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [1:0] CFG_WAYS       = 2'd1;
	localparam logic [1:0] CFG_BLOCK_BITS = 2'd2;

	// Fixed field widths of the interface.
	localparam int CFG_DATA_W  = 5;
	localparam int SET_OUT_W   = 6;
	localparam int WAY_OUT_W   = 3;
	localparam int BLOCK_MAX   = 16;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_REREAD
	} sacl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // latch the input address
		logic rd_en;     // read the set row
		logic update;    // write back the row and load the result
		logic last;      // result is the final one of its input
	} sacl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;  // the result register can take a new result
	} sacl_stat_t;

endpackage

// File: hdl/sacl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/sacl_ctrl.sv
// Controller state machine: sequences the read, lookup and write-back of each access.
module sacl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [1:0]           cmd,
	output logic                 in_stall,
	input  sacl_pkg::sacl_stat_t stat,
	output sacl_pkg::sacl_cmd_t  ctl
);
	import sacl_pkg::*;

	sacl_state_t state_q, state_d;
	logic        mod_q;
	logic        second_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (stat.out_free) begin
					state_d = (mod_q && !second_q) ? ST_REREAD : ST_IDLE;
				end
			end
			ST_REREAD: state_d = ST_LOOK;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_stall    = 1'b1;
		ctl.capture = 1'b0;
		ctl.rd_en   = 1'b0;
		ctl.update  = 1'b0;
		ctl.last    = !mod_q || second_q;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				ctl.capture = in_valid;
				ctl.rd_en   = in_valid;
			end
			ST_LOOK:   ctl.update = stat.out_free;
			ST_REREAD: ctl.rd_en = 1'b1;
			default:   in_stall = 1'b1;
		endcase
	end

	// State and access bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mod_q    <= 1'b0;
			second_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.capture) begin
				mod_q    <= (cmd == CMD_MODIFY);
				second_q <= 1'b0;
			end else if (state_q == ST_LOOK && state_d == ST_REREAD) begin
				second_q <= 1'b1;
			end
		end
	end

endmodule

// File: hdl/sacl_dp.sv
// Datapath: configuration, tag-store row memory, hit and victim logic, totals and result register.
module sacl_dp #(
	parameter int SET_BITS_MAX = 6,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_WIDTH   = 48,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [sacl_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic [ADDR_WIDTH-1:0]                addr,
	input  sacl_pkg::sacl_cmd_t                  ctl,
	output sacl_pkg::sacl_stat_t                 stat,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 hit,
	output logic                                 evicted,
	output logic [sacl_pkg::SET_OUT_W-1:0]       set_used,
	output logic [sacl_pkg::WAY_OUT_W-1:0]       way_used,
	output logic [COUNT_WIDTH-1:0]               hit_total,
	output logic [COUNT_WIDTH-1:0]               miss_total,
	output logic [COUNT_WIDTH-1:0]               eviction_total,
	output logic                                 last
);
	import sacl_pkg::*;

	localparam int SI_W   = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
	localparam int SETS   = 1 << SET_BITS_MAX;
	localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAY_W  = RANK_W;
	localparam int ROW_W  = MAX_WAYS * (1 + ADDR_WIDTH + RANK_W);
	localparam int TAG_LO = MAX_WAYS;
	localparam int RNK_LO = MAX_WAYS * (1 + ADDR_WIDTH);

	logic [2:0]            set_bits_q;
	logic [3:0]            ways_q;
	logic [4:0]            block_bits_q;
	logic [ADDR_WIDTH-1:0] addr_q;
	logic [SI_W-1:0]       set_q;
	logic                  rd_vld_q;
	logic [SETS-1:0]       row_vld_q;
	logic [ROW_W-1:0]      rd_row;
	logic [ROW_W-1:0]      wr_row;
	logic [COUNT_WIDTH-1:0] hit_cnt_q, miss_cnt_q, evict_cnt_q;
	logic                  out_valid_q, hit_q, evicted_q, last_q;
	logic [SI_W-1:0]       set_out_q;
	logic [WAY_W-1:0]      way_q;

	logic [3:0]            sb;
	logic [4:0]            bb;
	logic [4:0]            nw;
	logic [SI_W-1:0]       rd_set;
	logic [ADDR_WIDTH-1:0] tag;

	logic                  vld_w  [MAX_WAYS];
	logic [ADDR_WIDTH-1:0] tag_w  [MAX_WAYS];
	logic [RANK_W-1:0]     rank_w [MAX_WAYS];
	logic                  use_w  [MAX_WAYS];
	logic                  hit_c, evict_c, have_inv;
	logic [WAY_W-1:0]      way_c, hit_way, inv_way, lru_way;
	logic [RANK_W-1:0]     best;
	logic [RANK_W:0]       old_rank;

	// Set index of an address under the current configuration.
	function automatic logic [SI_W-1:0] set_of(input logic [ADDR_WIDTH-1:0] a,
			input logic [3:0] s, input logic [4:0] b);
		logic [ADDR_WIDTH-1:0] mask;
		mask = (ADDR_WIDTH'(1) << s) - ADDR_WIDTH'(1);
		return SI_W'((a >> b) & mask);
	endfunction

	// Clamped configuration values.
	always_comb begin
		sb = (4'(set_bits_q) > 4'(SET_BITS_MAX)) ? 4'(SET_BITS_MAX) : 4'(set_bits_q);
		bb = (block_bits_q > 5'(BLOCK_MAX)) ? 5'(BLOCK_MAX) : block_bits_q;
		if (ways_q == 4'd0) begin
			nw = 5'd1;
		end else if ({1'b0, ways_q} > 5'(MAX_WAYS)) begin
			nw = 5'(MAX_WAYS);
		end else begin
			nw = {1'b0, ways_q};
		end
		rd_set = ctl.capture ? set_of(addr, sb, bb) : set_of(addr_q, sb, bb);
		tag    = addr_q >> (6'(sb) + 6'(bb));
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= 3'd4;
			ways_q       <= 4'd1;
			block_bits_q <= 5'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_BITS:   set_bits_q   <= cfg_wdata[2:0];
				CFG_WAYS:       ways_q       <= cfg_wdata[3:0];
				CFG_BLOCK_BITS: block_bits_q <= cfg_wdata;
				default:        ;
			endcase
		end
	end

	// Row memory: valid bits, tags and ranks of one set per entry.
	sacl_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_rows (
		.clk   (clk),
		.we    (ctl.update),
		.waddr (set_q),
		.wdata (wr_row),
		.re    (ctl.rd_en),
		.raddr (rd_set),
		.rdata (rd_row)
	);

	// Address capture and read bookkeeping.
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			addr_q <= addr;
		end
		if (ctl.rd_en) begin
			set_q <= rd_set;
		end
	end

	// Per-row written flags; an unwritten row reads as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (ctl.rd_en) begin
				rd_vld_q <= row_vld_q[rd_set];
			end
			if (ctl.update) begin
				row_vld_q[set_q] <= 1'b1;
			end
		end
	end

	// Unpack the row that was read.
	always_comb begin
		for (int j = 0; j < MAX_WAYS; j++) begin
			vld_w[j]  = rd_vld_q & rd_row[j];
			tag_w[j]  = rd_vld_q ? rd_row[TAG_LO + j*ADDR_WIDTH +: ADDR_WIDTH] : '0;
			rank_w[j] = rd_vld_q ? rd_row[RNK_LO + j*RANK_W +: RANK_W] : '0;
			use_w[j]  = 5'(j) < nw;
		end
	end

	// Hit search, victim choice and the new row.
	always_comb begin
		hit_c    = 1'b0;
		hit_way  = '0;
		have_inv = 1'b0;
		inv_way  = '0;
		lru_way  = '0;
		best     = rank_w[0];
		for (int j = MAX_WAYS - 1; j >= 0; j--) begin
			if (use_w[j] && vld_w[j] && tag_w[j] == tag) begin
				hit_c   = 1'b1;
				hit_way = WAY_W'(j);
			end
		end
		for (int j = 0; j < MAX_WAYS; j++) begin
			if (use_w[j] && !vld_w[j]) begin
				have_inv = 1'b1;
				inv_way  = WAY_W'(j);
			end
		end
		for (int j = 1; j < MAX_WAYS; j++) begin
			if (use_w[j] && rank_w[j] > best) begin
				best    = rank_w[j];
				lru_way = WAY_W'(j);
			end
		end
		evict_c  = !hit_c && !have_inv;
		way_c    = hit_c ? hit_way : (have_inv ? inv_way : lru_way);
		old_rank = hit_c ? {1'b0, rank_w[way_c]} : (RANK_W+1)'(MAX_WAYS);
		for (int j = 0; j < MAX_WAYS; j++) begin
			wr_row[j] = vld_w[j];
			wr_row[TAG_LO + j*ADDR_WIDTH +: ADDR_WIDTH] = tag_w[j];
			wr_row[RNK_LO + j*RANK_W +: RANK_W] = rank_w[j];
			if (WAY_W'(j) == way_c) begin
				wr_row[j] = 1'b1;
				wr_row[TAG_LO + j*ADDR_WIDTH +: ADDR_WIDTH] = hit_c ? tag_w[j] : tag;
				wr_row[RNK_LO + j*RANK_W +: RANK_W] = '0;
			end else if (use_w[j] && vld_w[j] && {1'b0, rank_w[j]} < old_rank &&
					{1'b0, rank_w[j]} < (RANK_W+1)'(MAX_WAYS - 1)) begin
				wr_row[RNK_LO + j*RANK_W +: RANK_W] = rank_w[j] + RANK_W'(1);
			end
		end
	end

	// Saturating totals; they change only when a result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
		end else if (ctl.update) begin
			if (hit_c && hit_cnt_q != '1) begin
				hit_cnt_q <= hit_cnt_q + COUNT_WIDTH'(1);
			end
			if (!hit_c && miss_cnt_q != '1) begin
				miss_cnt_q <= miss_cnt_q + COUNT_WIDTH'(1);
			end
			if (evict_c && evict_cnt_q != '1) begin
				evict_cnt_q <= evict_cnt_q + COUNT_WIDTH'(1);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.update) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.update) begin
			hit_q     <= hit_c;
			evicted_q <= evict_c;
			set_out_q <= set_q;
			way_q     <= way_c;
			last_q    <= ctl.last;
		end
	end

	assign stat.out_free  = !out_valid_q || !out_stall;
	assign out_valid      = out_valid_q;
	assign hit            = hit_q;
	assign evicted        = evicted_q;
	assign set_used       = SET_OUT_W'(set_out_q);
	assign way_used       = WAY_OUT_W'(way_q);
	assign hit_total      = hit_cnt_q;
	assign miss_total     = miss_cnt_q;
	assign eviction_total = evict_cnt_q;
	assign last           = last_q;

endmodule

// File: hdl/set_assoc_lru_cache_sim_core.sv
// Top level of the set-associative LRU cache tag-store model.
//
// Input channel (in_valid/in_stall) takes one beat per memory operation:
// cmd (load, store or modify) and a byte address. A load or a store makes
// one access; a modify makes two accesses to the same set and so two
// result beats, only the second with last set.
// Output channel (out_valid/out_stall) gives one beat per access: hit,
// eviction, set and way used, and the running saturating totals.
// Each access reads its set row from the row memory into the registered
// read data, then checks, updates and writes it back while loading the
// result register. The block takes no new beat until its last access has
// been written back; a modify rereads its set after the first result is
// loaded. The single row memory sets this.
// While a result waits under out_stall the next input beat is still
// accepted and read; its write-back waits until the result register frees.
// Reset returns the configuration to 16 sets, one way and 16-byte blocks,
// clears all lines and totals at once (no clearing pass), and leaves the
// block ready. Configuration must be written only while the block is idle.
module set_assoc_lru_cache_sim_core #(
	parameter int SET_BITS_MAX = 6,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_WIDTH   = 48,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      cmd,
	input  logic [ADDR_WIDTH-1:0]           addr,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            hit,
	output logic                            evicted,
	output logic [sacl_pkg::SET_OUT_W-1:0]  set_used,
	output logic [sacl_pkg::WAY_OUT_W-1:0]  way_used,
	output logic [COUNT_WIDTH-1:0]          hit_total,
	output logic [COUNT_WIDTH-1:0]          miss_total,
	output logic [COUNT_WIDTH-1:0]          eviction_total,
	output logic                            last
);
	import sacl_pkg::*;

	sacl_cmd_t  ctl;
	sacl_stat_t stat;

	// Sequencer.
	sacl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	// Tag store and result path.
	sacl_dp #(
		.SET_BITS_MAX (SET_BITS_MAX),
		.MAX_WAYS     (MAX_WAYS),
		.ADDR_WIDTH   (ADDR_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.addr           (addr),
		.ctl            (ctl),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hit            (hit),
		.evicted        (evicted),
		.set_used       (set_used),
		.way_used       (way_used),
		.hit_total      (hit_total),
		.miss_total     (miss_total),
		.eviction_total (eviction_total),
		.last           (last)
	);

	// An accepted beat keeps the block busy on the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted on two consecutive cycles");

	// While the first result of a modify is pending the second access is still open.
	a_first_half_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> in_stall)
		else $error("new input taken before the second access of a modify");

	// A hit never evicts.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && evicted))
		else $error("result marked as both hit and eviction");

endmodule

// File: dv/tb_set_assoc_lru_cache_sim_core.sv
// Self-checking testbench for the set-associative LRU cache tag-store core.
module tb_set_assoc_lru_cache_sim_core;
	timeunit 1ns;
	timeprecision 1ps;

	import sacl_pkg::*;

	localparam int SB_MAX = 6;
	localparam int NW_MAX = 8;
	localparam int AW     = 48;
	localparam int CW     = 32;
	localparam int NLINES = (1 << SB_MAX) * NW_MAX;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]    cmd;
		logic [AW-1:0] addr;
	} op_t;

	typedef struct packed {
		logic          hit;
		logic          evicted;
		logic [5:0]    set_used;
		logic [2:0]    way_used;
		logic [CW-1:0] hit_total;
		logic [CW-1:0] miss_total;
		logic [CW-1:0] eviction_total;
		logic          last;
	} access_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_SET_BITS;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = CMD_LOAD;
	logic [AW-1:0] addr = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit, evicted, last;
	logic [5:0] set_used;
	logic [2:0] way_used;
	logic [CW-1:0] hit_total, miss_total, eviction_total;

	set_assoc_lru_cache_sim_core i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .addr(addr), .out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .evicted(evicted), .set_used(set_used), .way_used(way_used),
		.hit_total(hit_total), .miss_total(miss_total),
		.eviction_total(eviction_total), .last(last)
	);

	always #2 clk = ~clk;

	// Shadow copy of the tag store and configuration.
	logic [2:0] cfg_sb;
	logic [3:0] cfg_ways;
	logic [4:0] cfg_bb;
	logic          sh_valid [NLINES];
	logic [AW-1:0] sh_tag [NLINES];
	logic [2:0]    sh_rank [NLINES];
	logic [CW-1:0] sh_hits, sh_misses, sh_evicts;

	op_t     pending_ops [$];
	access_t expected_accesses [$];
	int errors = 0;
	int n_results = 0;
	int idle_cycles = 0;
	int hold_left = 0;
	logic hold_out;

	assign hold_out = (hold_left > 0);

	function automatic logic [CW-1:0] sat_inc(logic [CW-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Move a line to the front of its set's recency order.
	function automatic void promote(int base, int nw, int w, int old);
		for (int j = 0; j < nw; j++)
			if (j != w && sh_valid[base+j] && sh_rank[base+j] < old &&
			    sh_rank[base+j] < NW_MAX - 1)
				sh_rank[base+j]++;
		sh_rank[base+w] = 0;
	endfunction

	// Predict one cache access and queue its result.
	function automatic void predict_access(logic [AW-1:0] a, logic is_last);
		int sb, bb, nw, set, base, way, best;
		logic [AW-1:0] tag;
		access_t r;
		bit h, ev, inv;
		sb = (cfg_sb > SB_MAX) ? SB_MAX : cfg_sb;
		bb = (cfg_bb > BLOCK_MAX) ? BLOCK_MAX : cfg_bb;
		nw = (cfg_ways == 0) ? 1 : ((cfg_ways > NW_MAX) ? NW_MAX : cfg_ways);
		set = int'((a >> bb) & ((64'd1 << sb) - 1));
		tag = a >> (sb + bb);
		base = set * NW_MAX;
		h = 0; ev = 0; inv = 0; way = 0;
		for (int j = 0; j < nw; j++)
			if (!h && sh_valid[base+j] && sh_tag[base+j] == tag) begin
				h = 1;
				way = j;
			end
		if (h) begin
			sh_hits = sat_inc(sh_hits);
			promote(base, nw, way, sh_rank[base+way]);
		end else begin
			sh_misses = sat_inc(sh_misses);
			for (int j = 0; j < nw; j++)
				if (!sh_valid[base+j]) begin
					inv = 1;
					way = j;
				end
			if (!inv) begin
				best = 0;
				way = 0;
				for (int j = 0; j < nw; j++)
					if (j == 0 || sh_rank[base+j] > best) begin
						best = sh_rank[base+j];
						way = j;
					end
				ev = 1;
				sh_evicts = sat_inc(sh_evicts);
			end
			promote(base, nw, way, NW_MAX);
			sh_valid[base+way] = 1;
			sh_tag[base+way] = tag;
		end
		r.hit = h;
		r.evicted = ev;
		r.set_used = set[5:0];
		r.way_used = way[2:0];
		r.hit_total = sh_hits;
		r.miss_total = sh_misses;
		r.eviction_total = sh_evicts;
		r.last = is_last;
		expected_accesses.push_back(r);
	endfunction

	// Driver: offer queued operations with random gaps.
	int gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (cmd == CMD_MODIFY) begin
					predict_access(addr, 1'b0);
					predict_access(addr, 1'b1);
				end else
					predict_access(addr, 1'b1);
			end
			if (!in_valid || !in_stall) begin
				if (in_valid && !in_stall)
					gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
						: $urandom_range(0, 2) * $urandom_range(0, 1);
				if (gap > 0) begin
					gap--;
					in_valid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					op_t o;
					o = pending_ops.pop_front();
					cmd <= o.cmd;
					addr <= o.addr;
					in_valid <= 1'b1;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold, counted down in its own process.
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left--;
	end

	// Monitor: compare each result beat and drive random stalls.
	int stall_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				access_t e;
				n_results++;
				if (expected_accesses.size() == 0) begin
					errors++;
					$error("result beat with nothing expected");
				end else begin
					e = expected_accesses.pop_front();
					if (hit !== e.hit) begin errors++; $error("hit exp %0d got %0d", e.hit, hit); end
					if (evicted !== e.evicted) begin
						errors++; $error("evicted exp %0d got %0d", e.evicted, evicted);
					end
					if (set_used !== e.set_used) begin
						errors++; $error("set_used exp %0d got %0d", e.set_used, set_used);
					end
					if (way_used !== e.way_used) begin
						errors++; $error("way_used exp %0d got %0d", e.way_used, way_used);
					end
					if (hit_total !== e.hit_total) begin
						errors++; $error("hit_total exp %0d got %0d", e.hit_total, hit_total);
					end
					if (miss_total !== e.miss_total) begin
						errors++; $error("miss_total exp %0d got %0d", e.miss_total, miss_total);
					end
					if (eviction_total !== e.eviction_total) begin
						errors++;
						$error("eviction_total exp %0d got %0d", e.eviction_total, eviction_total);
					end
					if (last !== e.last) begin errors++; $error("last exp %0d got %0d", e.last, last); end
				end
			end
			if (hold_out) begin
				out_stall <= 1'b1;
				stall_left = 0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50)
					: $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	// Watchdog on cycles where neither channel moves a beat.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else if (arst_n && !hold_out)
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_ops.size() > 0 || in_valid || expected_accesses.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [4:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SET_BITS) cfg_sb = val[2:0];
		else if (idx == CFG_WAYS) cfg_ways = val[3:0];
		else cfg_bb = val;
	endtask

	task automatic push_op(logic [1:0] c, logic [AW-1:0] a);
		op_t o;
		o.cmd = c;
		o.addr = a;
		pending_ops.push_back(o);
	endtask

	function automatic logic [AW-1:0] rand_addr();
		return AW'({$urandom(), $urandom()});
	endfunction

	// A small pool of addresses so that sets see reuse and eviction.
	function automatic logic [AW-1:0] pool_addr(int span);
		logic [AW-1:0] a;
		a = (AW'($urandom_range(0, span)) << 24) | (AW'($urandom_range(0, 3)) << 12) |
			(AW'($urandom_range(0, 255)) << 4);
		if ($urandom_range(0, 3) == 0) a ^= AW'($urandom_range(0, 15));
		return a;
	endfunction

	initial begin
		cfg_sb = 3'd4;
		cfg_ways = 4'd1;
		cfg_bb = 5'd4;
		for (int i = 0; i < NLINES; i++) begin
			sh_valid[i] = 0; sh_tag[i] = '0; sh_rank[i] = '0;
		end
		sh_hits = '0; sh_misses = '0; sh_evicts = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset config, field extremes, all commands, unknown command.
		push_op(CMD_LOAD, '0);
		push_op(CMD_STORE, '1);
		push_op(CMD_MODIFY, '0);
		push_op(CMD_RESERVED, 48'h0000_0000_0010);
		push_op(CMD_LOAD, 48'h0000_0000_0010);
		push_op(CMD_MODIFY, 48'hAAAA_5555_AAAA);
		push_op(CMD_STORE, 48'h5555_AAAA_5555);
		wait_drained();

		// Out-of-range settings saturate; fill every way of set 0 and force evictions.
		write_reg(CFG_SET_BITS, 5'd7);
		write_reg(CFG_WAYS, 5'd15);
		write_reg(CFG_BLOCK_BITS, 5'd31);
		for (int i = 0; i < 12; i++) push_op(CMD_LOAD, AW'(i) << 22);
		for (int i = 0; i < 4; i++) push_op(CMD_MODIFY, AW'(i) << 22);
		wait_drained();

		// Ways zero acts as one; config change with valid lines kept.
		write_reg(CFG_WAYS, 5'd0);
		write_reg(CFG_SET_BITS, 5'd0);
		write_reg(CFG_BLOCK_BITS, 5'd0);
		push_op(CMD_LOAD, 48'h1);
		push_op(CMD_LOAD, 48'h2);
		push_op(CMD_LOAD, 48'h2);
		wait_drained();

		// Random phases across several settings, with one receiver-hold phase inside.
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_SET_BITS, 5'($urandom_range(0, 7)));
			write_reg(CFG_WAYS, 5'($urandom_range(0, 15)));
			write_reg(CFG_BLOCK_BITS, 5'($urandom_range(0, 20)));
			for (int i = 0; i < 105; i++) begin
				logic [1:0] c;
				c = ($urandom_range(0, 19) == 0) ? CMD_RESERVED : 2'($urandom_range(0, 2));
				push_op(c, ($urandom_range(0, 9) == 0) ? rand_addr() : pool_addr(7));
			end
			if (ph == 2) begin
				// Receiver holds off while the sender keeps offering.
				hold_left = 300;
				wait (hold_left == 0);
			end
			wait_drained();
		end

		$display("Covered %0d result beats over directed, saturating and eight random setups.",
			n_results);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
